FILE: rtl/core/dbic_pkg.sv
package dbic_pkg;

    localparam int KEY_DEPTH = 16;
    localparam int KEY_CNT_W = $clog2(KEY_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_BYTE   = 3'd0,
        CMD_POLL   = 3'd1,
        CMD_MOVE   = 3'd2,
        CMD_BUTTON = 3'd3,
        CMD_KEY    = 3'd4,
        CMD_RESET  = 3'd5
    } cmd_t;

    localparam logic [1:0] TALK_CODE     = 2'd3;
    localparam logic [1:0] REG_ZERO      = 2'd0;
    localparam logic [3:0] MOUSE_ADDR    = 4'd3;
    localparam logic [3:0] KEYBOARD_ADDR = 4'd2;

    typedef struct packed {
        logic add;
        logic set_button;
        logic poll;
        logic clear;
    } mouse_ctl_t;

    typedef struct packed {
        logic push;
        logic poll;
        logic clear;
    } keyq_ctl_t;

endpackage

FILE: rtl/core/dbic_mouse.sv
module dbic_mouse
    import dbic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  mouse_ctl_t  ctl,
    input  logic [15:0] delta_x,
    input  logic [15:0] delta_y,
    input  logic        button_down,
    output logic        has_data,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte
);

    logic [15:0] accum_x_reg, accum_x_next;
    logic [15:0] accum_y_reg, accum_y_next;
    logic        button_reg, button_next;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {a[15], a} + {b[15], b};
        if (s[16] != s[15]) begin
            sat_add16 = s[16] ? 16'h8000 : 16'h7FFF;
        end else begin
            sat_add16 = s[15:0];
        end
    endfunction

    function automatic logic [6:0] clamp7(input logic [15:0] v);
        if ($signed(v) > 16'sd63) begin
            clamp7 = 7'h3F;
        end else if ($signed(v) < -16'sd64) begin
            clamp7 = 7'h40;
        end else begin
            clamp7 = v[6:0];
        end
    endfunction

    assign has_data    = (accum_x_reg != 16'd0) || (accum_y_reg != 16'd0) || button_reg;
    assign first_byte  = {~button_reg, clamp7(accum_y_reg)};
    assign second_byte = {1'b1, clamp7(accum_x_reg)};

    always_comb begin
        accum_x_next = accum_x_reg;
        accum_y_next = accum_y_reg;
        button_next  = button_reg;
        if (ctl.clear) begin
            accum_x_next = 16'd0;
            accum_y_next = 16'd0;
            button_next  = 1'b0;
        end else if (ctl.add) begin
            accum_x_next = sat_add16(accum_x_reg, delta_x);
            accum_y_next = sat_add16(accum_y_reg, delta_y);
        end else if (ctl.set_button) begin
            button_next = button_down;
        end else if (ctl.poll && has_data) begin
            accum_x_next = 16'd0;
            accum_y_next = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_x_reg <= 16'd0;
            accum_y_reg <= 16'd0;
            button_reg  <= 1'b0;
        end else begin
            accum_x_reg <= accum_x_next;
            accum_y_reg <= accum_y_next;
            button_reg  <= button_next;
        end
    end

endmodule

FILE: rtl/core/dbic_keyq.sv
module dbic_keyq
    import dbic_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  keyq_ctl_t  ctl,
    input  logic [7:0] key_byte,
    output logic       has_data,
    output logic [7:0] first_byte,
    output logic [7:0] second_byte
);

    logic [7:0]           store_reg  [KEY_DEPTH + 2];
    logic [7:0]           store_next [KEY_DEPTH];
    logic [KEY_CNT_W-1:0] count_reg, count_next;
    logic                 pop_two;

    assign pop_two     = count_reg > KEY_CNT_W'(1);
    assign has_data    = count_reg != '0;
    assign first_byte  = store_reg[0];
    assign second_byte = pop_two ? store_reg[1] : 8'hFF;

    // head of the queue always sits in entry 0
    always_comb begin
        count_next = count_reg;
        for (int i = 0; i < KEY_DEPTH; i++) begin
            store_next[i] = store_reg[i];
        end
        if (ctl.clear) begin
            count_next = '0;
        end else if (ctl.poll && has_data) begin
            if (pop_two) begin
                count_next = count_reg - KEY_CNT_W'(2);
                for (int i = 0; i < KEY_DEPTH; i++) begin
                    store_next[i] = store_reg[i + 2];
                end
            end else begin
                count_next = count_reg - KEY_CNT_W'(1);
                for (int i = 0; i < KEY_DEPTH; i++) begin
                    store_next[i] = store_reg[i + 1];
                end
            end
        end else if (ctl.push && (count_reg < KEY_CNT_W'(KEY_DEPTH))) begin
            count_next = count_reg + KEY_CNT_W'(1);
            for (int i = 0; i < KEY_DEPTH; i++) begin
                if (count_reg == KEY_CNT_W'(i)) begin
                    store_next[i] = key_byte;
                end
            end
        end
    end

    // two spare entries past the end keep the shift uniform
    always_ff @(posedge aclk) begin
        for (int i = 0; i < KEY_DEPTH; i++) begin
            store_reg[i] <= store_next[i];
        end
        store_reg[KEY_DEPTH]     <= 8'hFF;
        store_reg[KEY_DEPTH + 1] <= 8'hFF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/desktop_bus_input_controller_unit.sv
// Desktop-bus host controller for one mouse (address 3) and one keyboard
// (address 2). Each input transaction is captured in an input register and
// handled from there; a poll loads the result register, all other commands
// only update state. One transaction per cycle is sustained while no poll
// waits, and a handled poll's result is valid in the following cycle; a poll
// waits in the input register only while an earlier result has not been
// taken. Key events arriving with a full 16-entry queue are dropped.
module desktop_bus_input_controller_unit
    import dbic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_cmd_byte,
    input  logic [15:0] s_delta_x,
    input  logic [15:0] s_delta_y,
    input  logic        s_button_down,
    input  logic [7:0]  s_keycode,
    input  logic        s_key_down,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_has_data,
    output logic [1:0]  m_byte_count,
    output logic [7:0]  m_first_byte,
    output logic [7:0]  m_second_byte
);

    logic        in_valid_reg;
    cmd_t        cmd_reg;
    logic [7:0]  cmd_byte_reg;
    logic [15:0] delta_x_reg;
    logic [15:0] delta_y_reg;
    logic        button_down_reg;
    logic [7:0]  keycode_reg;
    logic        key_down_reg;

    logic [3:0]  device_address_reg;
    logic [1:0]  command_code_reg;
    logic [1:0]  register_select_reg;

    logic        m_valid_reg;
    logic        m_has_data_reg;
    logic [1:0]  m_byte_count_reg;
    logic [7:0]  m_first_byte_reg;
    logic [7:0]  m_second_byte_reg;

    logic        is_poll;
    logic        proc;
    logic        talk0;
    logic        mouse_sel;
    logic        key_sel;
    logic        reply_has;
    logic [7:0]  reply_first;
    logic [7:0]  reply_second;
    logic [7:0]  key_byte;

    mouse_ctl_t  mouse_ctl;
    keyq_ctl_t   keyq_ctl;
    logic        mouse_has;
    logic [7:0]  mouse_first;
    logic [7:0]  mouse_second;
    logic        key_has;
    logic [7:0]  key_first;
    logic [7:0]  key_second;

    assign is_poll = in_valid_reg && (cmd_reg == CMD_POLL);
    assign proc    = in_valid_reg && (!is_poll || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;

    assign talk0     = (command_code_reg == TALK_CODE) && (register_select_reg == REG_ZERO);
    assign mouse_sel = talk0 && (device_address_reg == MOUSE_ADDR);
    assign key_sel   = talk0 && (device_address_reg == KEYBOARD_ADDR);
    assign key_byte  = key_down_reg ? keycode_reg : (keycode_reg | 8'h80);

    assign mouse_ctl.add        = proc && (cmd_reg == CMD_MOVE);
    assign mouse_ctl.set_button = proc && (cmd_reg == CMD_BUTTON);
    assign mouse_ctl.poll       = proc && is_poll && mouse_sel;
    assign mouse_ctl.clear      = proc && (cmd_reg == CMD_RESET);

    assign keyq_ctl.push  = proc && (cmd_reg == CMD_KEY);
    assign keyq_ctl.poll  = proc && is_poll && key_sel;
    assign keyq_ctl.clear = proc && (cmd_reg == CMD_RESET);

    dbic_mouse u_mouse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (mouse_ctl),
        .delta_x     (delta_x_reg),
        .delta_y     (delta_y_reg),
        .button_down (button_down_reg),
        .has_data    (mouse_has),
        .first_byte  (mouse_first),
        .second_byte (mouse_second)
    );

    dbic_keyq u_keyq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (keyq_ctl),
        .key_byte    (key_byte),
        .has_data    (key_has),
        .first_byte  (key_first),
        .second_byte (key_second)
    );

    always_comb begin
        reply_has    = 1'b0;
        reply_first  = 8'd0;
        reply_second = 8'd0;
        if (mouse_sel && mouse_has) begin
            reply_has    = 1'b1;
            reply_first  = mouse_first;
            reply_second = mouse_second;
        end else if (key_sel && key_has) begin
            reply_has    = 1'b1;
            reply_first  = key_first;
            reply_second = key_second;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg         <= cmd_t'(s_cmd);
            cmd_byte_reg    <= s_cmd_byte;
            delta_x_reg     <= s_delta_x;
            delta_y_reg     <= s_delta_y;
            button_down_reg <= s_button_down;
            keycode_reg     <= s_keycode;
            key_down_reg    <= s_key_down;
        end
    end

    // latched bus command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg  <= 4'd0;
            command_code_reg    <= 2'd0;
            register_select_reg <= 2'd0;
        end else if (proc) begin
            case (cmd_reg)
                CMD_BYTE: begin
                    device_address_reg  <= cmd_byte_reg[7:4];
                    command_code_reg    <= cmd_byte_reg[3:2];
                    register_select_reg <= cmd_byte_reg[1:0];
                end
                CMD_RESET: begin
                    device_address_reg  <= 4'd0;
                    command_code_reg    <= 2'd0;
                    register_select_reg <= 2'd0;
                end
                default: begin
                    device_address_reg  <= device_address_reg;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc && is_poll) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && is_poll) begin
            m_has_data_reg    <= reply_has;
            m_byte_count_reg  <= reply_has ? 2'd2 : 2'd0;
            m_first_byte_reg  <= reply_first;
            m_second_byte_reg <= reply_second;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_has_data    = m_has_data_reg;
    assign m_byte_count  = m_byte_count_reg;
    assign m_first_byte  = m_first_byte_reg;
    assign m_second_byte = m_second_byte_reg;

    a_stall_blocks_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        is_poll && m_valid && !m_ready |-> !s_ready)
        else $error("poll proceeded while result register was full");

    a_no_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_data |-> (m_byte_count == 2'd0) && (m_first_byte == 8'd0)
            && (m_second_byte == 8'd0))
        else $error("empty reply carries nonzero bytes");

    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_data |-> m_byte_count == 2'd2)
        else $error("reply with data has wrong byte count");

    a_poll_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && is_poll |=> m_valid)
        else $error("handled poll produced no result");

endmodule
